### rtl/htag_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and character constants for the HTTP request byte tagger.
// No dependencies; every other file of the block imports this package.
package htag_pkg;

	localparam int unsigned SEG_W   = 11;
	localparam int unsigned MPOS_W  = 4;
	localparam logic [SEG_W-1:0] MAX_URI = SEG_W'(1024);

	localparam logic [3:0] CLS_METHOD  = 4'd0;
	localparam logic [3:0] CLS_PATH    = 4'd1;
	localparam logic [3:0] CLS_QUERY   = 4'd2;
	localparam logic [3:0] CLS_VERSION = 4'd3;
	localparam logic [3:0] CLS_SEP     = 4'd4;
	localparam logic [3:0] CLS_HEADER  = 4'd5;
	localparam logic [3:0] CLS_COOKIE  = 4'd6;
	localparam logic [3:0] CLS_BODY    = 4'd7;
	localparam logic [3:0] CLS_REJ     = 4'd8;

	localparam logic [1:0] METH_NONE = 2'd0;
	localparam logic [1:0] METH_GET  = 2'd1;
	localparam logic [1:0] METH_POST = 2'd2;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_METHOD  = 2'd1;
	localparam logic [1:0] ERR_SLASH   = 2'd2;
	localparam logic [1:0] ERR_VERSION = 2'd3;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_QMARK = 8'h3f;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_P     = 8'h50;

	localparam logic [MPOS_W-1:0] GET_LEN    = MPOS_W'(4);
	localparam logic [MPOS_W-1:0] POST_LEN   = MPOS_W'(5);
	localparam logic [MPOS_W-1:0] VER_LEN    = MPOS_W'(9);
	localparam logic [MPOS_W-1:0] COOKIE_LEN = MPOS_W'(8);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} htag_item_t;

	typedef struct packed {
		logic [3:0] byte_class;
		logic [1:0] method_seen;
		logic [1:0] request_error;
	} htag_result_t;

	function automatic logic [7:0] method_char(input logic [1:0] meth,
			input logic [MPOS_W-1:0] pos);
		logic [7:0] c;
		c = CH_NUL;
		if (meth == METH_GET) begin
			case (pos)
				4'd0: c = "G";
				4'd1: c = "E";
				4'd2: c = "T";
				4'd3: c = " ";
				default: c = CH_NUL;
			endcase
		end else begin
			case (pos)
				4'd0: c = "P";
				4'd1: c = "O";
				4'd2: c = "S";
				4'd3: c = "T";
				4'd4: c = " ";
				default: c = CH_NUL;
			endcase
		end
		return c;
	endfunction

	function automatic logic [7:0] version_char(input logic [MPOS_W-1:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0: c = " ";
			4'd1: c = "H";
			4'd2: c = "T";
			4'd3: c = "T";
			4'd4: c = "P";
			4'd5: c = "/";
			4'd6: c = "1";
			4'd7: c = ".";
			4'd8: c = "1";
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] cookie_char(input logic [MPOS_W-1:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0: c = "C";
			4'd1: c = "o";
			4'd2: c = "o";
			4'd3: c = "k";
			4'd4: c = "i";
			4'd5: c = "e";
			4'd6: c = ":";
			4'd7: c = " ";
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

endpackage

### rtl/htag_in_stage.sv
`timescale 1ns / 1ps
// Input register stage: captures one item and holds it until the tagger takes it.
// Depends on htag_pkg for the item type.
module htag_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  htag_pkg::htag_item_t item_in,
	output logic              valid_s1,
	output htag_pkg::htag_item_t item_s1,
	input  logic              advance
);
	import htag_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_in;
		end
	end

endmodule

### rtl/htag_tagger.sv
`timescale 1ns / 1ps
// Parser state and the per-byte step that classifies one byte of the request.
// Depends on htag_pkg for codes, character tables and the result type.
module htag_tagger (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  htag_pkg::htag_item_t      item_s1,
	input  logic [htag_pkg::SEG_W-1:0] limit,
	output htag_pkg::htag_result_t    result
);
	import htag_pkg::*;

	typedef enum logic [3:0] {
		PH_METHOD    = 4'd0,
		PH_SLASH     = 4'd1,
		PH_PATH      = 4'd2,
		PH_QUERY     = 4'd3,
		PH_VERSION   = 4'd4,
		PH_TAIL      = 4'd5,
		PH_TAIL_CR   = 4'd6,
		PH_HEADER    = 4'd7,
		PH_HEADER_CR = 4'd8,
		PH_BODY      = 4'd9
	} phase_t;

	phase_t            phase_q, phase_n;
	logic [MPOS_W-1:0] mpos_q, mpos_n;
	logic [1:0]        meth_q, meth_n;
	logic [SEG_W-1:0]  seg_q, seg_n;
	logic [1:0]        err_q, err_n;
	logic              empty_q, empty_n;
	logic              cookie_q, cookie_n;
	logic [3:0]        cls;
	logic [7:0]        b;
	logic              cm;
	logic [MPOS_W-1:0] mlen;

	assign b = item_s1.data;

	always_comb begin
		phase_n  = phase_q;
		mpos_n   = mpos_q;
		meth_n   = meth_q;
		seg_n    = seg_q;
		err_n    = err_q;
		empty_n  = empty_q;
		cookie_n = cookie_q;
		cls      = CLS_REJ;
		cm       = cookie_q;
		mlen     = (meth_q == METH_GET) ? GET_LEN : POST_LEN;

		case (phase_q)
			PH_METHOD: begin
				if (mpos_q == '0) begin
					if (b == CH_G || b == CH_P) begin
						meth_n = (b == CH_G) ? METH_GET : METH_POST;
						mpos_n = MPOS_W'(1);
						cls    = CLS_METHOD;
					end else begin
						meth_n = METH_NONE;
						if (err_q == ERR_NONE) err_n = ERR_METHOD;
						phase_n = (b == CH_CR) ? PH_TAIL_CR : PH_TAIL;
						cls     = CLS_REJ;
					end
				end else if (mpos_q >= mlen || b != method_char(meth_q, mpos_q)) begin
					meth_n = METH_NONE;
					if (err_q == ERR_NONE) err_n = ERR_METHOD;
					phase_n = (b == CH_CR) ? PH_TAIL_CR : PH_TAIL;
					cls     = CLS_REJ;
				end else if (mpos_q + MPOS_W'(1) == mlen) begin
					phase_n = PH_SLASH;
					mpos_n  = '0;
					cls     = CLS_SEP;
				end else begin
					mpos_n = mpos_q + MPOS_W'(1);
					cls    = CLS_METHOD;
				end
			end
			PH_SLASH: begin
				if (b == CH_SLASH) begin
					phase_n = PH_PATH;
					seg_n   = SEG_W'(1);
					cls     = CLS_PATH;
				end else begin
					if (err_q == ERR_NONE) err_n = ERR_SLASH;
					phase_n = (b == CH_CR) ? PH_TAIL_CR : PH_TAIL;
					cls     = CLS_REJ;
				end
			end
			PH_PATH, PH_QUERY: begin
				if (seg_q < limit && b != CH_SP && b != CH_NUL && b != CH_CR
						&& !(phase_q == PH_PATH && b == CH_QMARK)) begin
					seg_n = seg_q + SEG_W'(1);
					cls   = (phase_q == PH_PATH) ? CLS_PATH : CLS_QUERY;
				end else if (phase_q == PH_PATH && b == CH_QMARK) begin
					phase_n = PH_QUERY;
					seg_n   = '0;
					cls     = CLS_SEP;
				end else if (b == CH_SP) begin
					phase_n = PH_VERSION;
					mpos_n  = MPOS_W'(1);
					cls     = CLS_SEP;
				end else begin
					if (err_q == ERR_NONE) err_n = ERR_VERSION;
					phase_n = (b == CH_CR) ? PH_TAIL_CR : PH_TAIL;
					cls     = CLS_REJ;
				end
			end
			PH_VERSION: begin
				if (mpos_q < VER_LEN && b == version_char(mpos_q)) begin
					cls = CLS_VERSION;
					if (mpos_q + MPOS_W'(1) >= VER_LEN) begin
						phase_n = PH_TAIL;
						mpos_n  = '0;
					end else begin
						mpos_n = mpos_q + MPOS_W'(1);
					end
				end else begin
					if (err_q == ERR_NONE) err_n = ERR_VERSION;
					phase_n = (b == CH_CR) ? PH_TAIL_CR : PH_TAIL;
					cls     = CLS_REJ;
				end
			end
			PH_TAIL: begin
				if (b == CH_CR) phase_n = PH_TAIL_CR;
				cls = (err_q != ERR_NONE) ? CLS_REJ : CLS_VERSION;
			end
			PH_TAIL_CR: begin
				if (b == CH_LF) begin
					phase_n  = PH_HEADER;
					empty_n  = 1'b1;
					cookie_n = 1'b1;
					mpos_n   = '0;
					cls      = CLS_SEP;
				end else if (b == CH_CR) begin
					cls = CLS_SEP;
				end else begin
					phase_n = PH_TAIL;
					cls     = (err_q != ERR_NONE) ? CLS_REJ : CLS_VERSION;
				end
			end
			PH_HEADER, PH_HEADER_CR: begin
				if (phase_q == PH_HEADER_CR && b == CH_LF) begin
					if (empty_q) begin
						phase_n = PH_BODY;
					end else begin
						phase_n  = PH_HEADER;
						empty_n  = 1'b1;
						cookie_n = 1'b1;
						mpos_n   = '0;
					end
					cls = CLS_SEP;
				end else begin
					if (phase_q == PH_HEADER_CR) begin
						empty_n = 1'b0;
						if (cookie_q && mpos_q < COOKIE_LEN) cm = 1'b0;
						cookie_n = cm;
					end
					if (b == CH_CR) begin
						phase_n = PH_HEADER_CR;
						cls     = CLS_SEP;
					end else begin
						phase_n = PH_HEADER;
						empty_n = 1'b0;
						cls     = CLS_HEADER;
						if (cm) begin
							if (mpos_q >= COOKIE_LEN) begin
								cls = CLS_COOKIE;
							end else if (b == cookie_char(mpos_q)) begin
								mpos_n = mpos_q + MPOS_W'(1);
							end else begin
								cookie_n = 1'b0;
							end
						end
					end
				end
			end
			default: begin
				phase_n = PH_BODY;
				cls     = CLS_BODY;
			end
		endcase

		if (b == CH_CR || b == CH_LF) cls = CLS_SEP;
	end

	assign result.byte_class    = cls;
	assign result.method_seen   = (phase_n == PH_METHOD) ? METH_NONE : meth_n;
	assign result.request_error = err_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_METHOD;
			mpos_q   <= '0;
			meth_q   <= METH_NONE;
			seg_q    <= '0;
			err_q    <= ERR_NONE;
			empty_q  <= 1'b1;
			cookie_q <= 1'b1;
		end else if (advance) begin
			if (item_s1.last) begin
				phase_q  <= PH_METHOD;
				mpos_q   <= '0;
				meth_q   <= METH_NONE;
				seg_q    <= '0;
				err_q    <= ERR_NONE;
				empty_q  <= 1'b1;
				cookie_q <= 1'b1;
			end else begin
				phase_q  <= phase_n;
				mpos_q   <= mpos_n;
				meth_q   <= meth_n;
				seg_q    <= seg_n;
				err_q    <= err_n;
				empty_q  <= empty_n;
				cookie_q <= cookie_n;
			end
		end
	end

endmodule

### rtl/http_request_byte_tagger.sv
`timescale 1ns / 1ps
// Top level of the HTTP request byte tagger: input stage, tagger and result register.
// Depends on htag_pkg, htag_in_stage and htag_tagger.

// Each byte of a request is tagged with its role (method, path, query, version,
// delimiter, header, cookie value, body or rejected) together with the latched
// method and first request-line error. Bytes pass the input register, then the result
// register, one per cycle unless out_ready holds them back. The combinational parser
// step between the registers sets the rate; a new item is accepted whenever the result
// register is empty or being emptied. The path limit register may be written only
// while no item is in flight; values of zero act as one and values above 1024 act
// as 1024.
module http_request_byte_tagger (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_in,
	input  logic        last_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  data_out,
	output logic [3:0]  byte_class,
	output logic [1:0]  method_seen,
	output logic [1:0]  request_error,
	output logic        last_out,
	input  logic        cfg_we,
	input  logic [10:0] cfg_data
);
	import htag_pkg::*;

	htag_item_t       item_in, item_s1, item_s2;
	htag_result_t     result, result_s2;
	logic             valid_s1, valid_s2, advance;
	logic [SEG_W-1:0] limit_q;

	assign item_in.data = data_in;
	assign item_in.last = last_in;
	assign advance = valid_s1 && (!valid_s2 || out_ready);

	htag_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item_in  (item_in),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.advance  (advance)
	);

	htag_tagger u_tagger (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.limit   (limit_q),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= MAX_URI;
		end else if (cfg_we) begin
			if (cfg_data == '0) begin
				limit_q <= SEG_W'(1);
			end else if (cfg_data > MAX_URI) begin
				limit_q <= MAX_URI;
			end else begin
				limit_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s2   <= item_s1;
			result_s2 <= result;
		end
	end

	assign out_valid     = valid_s2;
	assign data_out      = item_s2.data;
	assign last_out      = item_s2.last;
	assign byte_class    = result_s2.byte_class;
	assign method_seen   = result_s2.method_seen;
	assign request_error = result_s2.request_error;

	a_advance_fills : assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("Result register empty after an item moved into it");

	a_crlf_sep : assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (data_out == CH_CR || data_out == CH_LF) |-> byte_class == CLS_SEP)
		else $error("CR or LF not tagged as a delimiter");

	a_class_range : assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> byte_class <= CLS_REJ)
		else $error("Byte class out of range");

	a_reject_err : assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && request_error == ERR_NONE |-> byte_class != CLS_REJ)
		else $error("Rejected byte without a latched error");

endmodule
